### rtl/core/jcl_pkg.sv
// shared types, constants and helpers for the joystick code lock stepper
package jcl_pkg;

   localparam int CODE_LENGTH = 4;
   localparam int PHASE_COUNT = 8;

   localparam int SAMPLE_W = 10;
   localparam int CFG_W    = 10;
   localparam int CODE_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int INDEX_W  = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam int PHASE_W  = 3;
   localparam int COIL_W   = 4;
   localparam int SEG_W    = 7;
   localparam int LAMP_W   = 2;
   localparam int SYM_W    = 2;
   localparam int BLINK_TOTAL_W = 6;
   localparam int BLINK_PHASE_W = 3;

   localparam logic [SAMPLE_W-1:0] POLL_MAX = '1;
   localparam logic [BLINK_TOTAL_W-1:0] BLINK_PERIODS = BLINK_TOTAL_W'(40);
   localparam logic [BLINK_PHASE_W-1:0] BLINK_ON_LIMIT = BLINK_PHASE_W'(5);
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_COUNT - 1);
   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(CODE_LENGTH - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_POLL_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UP_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN_LIMIT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_STEPS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_WORD   = 3'd6;

   // register reset values
   localparam logic [CFG_W-1:0]  RST_POLL_PERIOD = 10'd200;
   localparam logic [CFG_W-1:0]  RST_LEFT_LIMIT  = 10'd400;
   localparam logic [CFG_W-1:0]  RST_RIGHT_LIMIT = 10'd600;
   localparam logic [CFG_W-1:0]  RST_UP_LIMIT    = 10'd20;
   localparam logic [CFG_W-1:0]  RST_DOWN_LIMIT  = 10'd1;
   localparam logic [CFG_W-1:0]  RST_TURN_STEPS  = 10'd900;
   localparam logic [CODE_W-1:0] RST_CODE_WORD   = 8'd228;

   // symbols
   localparam logic [SYM_W-1:0] SYM_UP    = 2'd0;
   localparam logic [SYM_W-1:0] SYM_RIGHT = 2'd1;
   localparam logic [SYM_W-1:0] SYM_LEFT  = 2'd2;
   localparam logic [SYM_W-1:0] SYM_DOWN  = 2'd3;

   // glyphs
   localparam logic [SEG_W-1:0] SEG_LEFT    = 7'b0001110;
   localparam logic [SEG_W-1:0] SEG_RIGHT   = 7'b0000101;
   localparam logic [SEG_W-1:0] SEG_UP      = 7'b0111110;
   localparam logic [SEG_W-1:0] SEG_DOWN    = 7'b0111101;
   localparam logic [SEG_W-1:0] SEG_NEUTRAL = 7'b0000001;

   // lamp values
   localparam logic [LAMP_W-1:0] LAMPS_ON  = 2'b11;
   localparam logic [LAMP_W-1:0] LAMPS_OFF = 2'b00;

   // entry states
   localparam logic ENTRY_READING = 1'b0;
   localparam logic ENTRY_UNLOCK  = 1'b1;

   // lamp states
   localparam logic [1:0] LAMP_IDLE  = 2'd0;
   localparam logic [1:0] LAMP_ON    = 2'd1;
   localparam logic [1:0] LAMP_BLINK = 2'd2;

   // motor states
   localparam logic [1:0] MOTOR_STAND = 2'd0;
   localparam logic [1:0] MOTOR_FWD   = 2'd1;
   localparam logic [1:0] MOTOR_BACK  = 2'd2;

   typedef logic [COIL_W-1:0] coil_table_type [8];
   localparam coil_table_type COIL_TABLE = '{
      4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000, 4'b1001
   };

   typedef struct packed {
      logic              busy;
      logic              is_open;
      logic              finish;
      logic [COIL_W-1:0] coil;
   } motor_status_type;

   // half-step pattern for a phase, table sampled evenly for shorter cycles
   function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] idx);
      logic [PHASE_W+3:0] scaled;
      scaled = ({4'd0, idx} * (PHASE_W + 4)'(8)) / (PHASE_W + 4)'(PHASE_COUNT);
      return COIL_TABLE[scaled[2:0]];
   endfunction

endpackage

### rtl/core/jcl_if.sv
// channel interfaces for the joystick code lock stepper
interface jcl_req_if
   import jcl_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] x_sample;
   logic [SAMPLE_W-1:0] y_sample;

   modport source (output valid, output x_sample, output y_sample, input ready);
   modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface jcl_rsp_if
   import jcl_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [COIL_W-1:0] coil_phase;
   logic [SEG_W-1:0]  segment_code;
   logic [LAMP_W-1:0] status_lamps;
   logic              is_open;
   logic              motor_busy;

   modport source (output valid, output coil_phase, output segment_code,
                   output status_lamps, output is_open, output motor_busy, input ready);
   modport sink   (input valid, input coil_phase, input segment_code,
                   input status_lamps, input is_open, input motor_busy, output ready);
endinterface

interface jcl_csr_if
   import jcl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/jcl_motor.sv
// stepper turn sequencer: half-step coil phases forward or backward per tick
module jcl_motor
   import jcl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic             request,
   input  logic [CFG_W-1:0] turn_steps,
   output motor_status_type status
);

   logic [1:0]         mode_ff, mode_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CFG_W-1:0]   step_ff, step_in;
   logic               open_ff, open_in;
   logic [COIL_W-1:0]  coil_ff, coil_in;
   logic               finish;
   logic [1:0]         mode_mid;
   logic [CFG_W-1:0]   step_mid;
   logic [PHASE_W-1:0] phase_back;

   always_comb begin
      mode_mid = mode_ff;
      step_mid = step_ff;
      mode_in  = mode_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      open_in  = open_ff;
      coil_in  = coil_ff;
      finish   = 1'b0;
      phase_back = (phase_ff == '0 || phase_ff > PHASE_LAST) ? PHASE_LAST
                                                            : phase_ff - PHASE_W'(1);
      if (mode_ff == MOTOR_STAND && request) begin
         mode_mid = open_ff ? MOTOR_BACK : MOTOR_FWD;
         step_mid = '0;
      end
      if (mode_mid != MOTOR_STAND) begin
         mode_in = mode_mid;
         if (step_mid < turn_steps) begin
            if (mode_mid == MOTOR_FWD) begin
               coil_in  = coil_of(phase_ff);
               phase_in = (phase_ff >= PHASE_LAST) ? '0 : phase_ff + PHASE_W'(1);
            end else begin
               phase_in = phase_back;
               coil_in  = coil_of(phase_back);
            end
            step_in = step_mid + CFG_W'(1);
         end else begin
            // one idle tick closes the turn
            phase_in = (mode_mid == MOTOR_FWD) ? PHASE_LAST : '0;
            step_in  = '0;
            finish   = 1'b1;
            open_in  = ~open_ff;
            mode_in  = MOTOR_STAND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MOTOR_STAND;
         phase_ff <= '0;
         step_ff  <= '0;
         open_ff  <= 1'b0;
         coil_ff  <= '0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         open_ff  <= open_in;
         coil_ff  <= coil_in;
      end
   end

   assign status.busy    = (mode_in != MOTOR_STAND);
   assign status.is_open = open_in;
   assign status.finish  = finish;
   assign status.coil    = coil_in;

endmodule

### rtl/core/joystick_code_lock_stepper_core.sv
// top level of the joystick code lock with stepper drive
//
// req_ch carries one timer tick per transaction with the joystick x and y
// samples; rsp_ch returns exactly one result transaction per tick with the
// coil pattern, glyph, lamps, open flag and busy flag after that tick.
// csr_ch writes the seven registers (poll period, four stick limits, turn
// steps, code word) by index; it is always ready and indexes past the code
// word are dropped. Write registers only while no tick is outstanding.
// The tick is evaluated in the accept cycle and the result register shows it
// on the next. Throughput is one tick per cycle while rsp_ch takes results;
// the single result register is the only buffer, so while rsp_ch stalls
// with a result pending, req_ch ready is low, and it rises in the cycle the
// result is taken. Reset (synchronous) loads the register defaults, clears
// all counters, flags, coil, glyph and lamps, and drops any pending result.
// Stored code symbols are not reset; each is written before it is compared.
module joystick_code_lock_stepper_core
   import jcl_pkg::*;
(
   input logic      clock,
   input logic      reset,
   jcl_req_if.sink   req_ch,
   jcl_rsp_if.source rsp_ch,
   jcl_csr_if.sink   csr_ch
);

   // configuration
   logic [CFG_W-1:0]  poll_period_ff, left_limit_ff, right_limit_ff;
   logic [CFG_W-1:0]  up_limit_ff, down_limit_ff, turn_steps_ff;
   logic [CODE_W-1:0] code_word_ff;

   // lock state
   logic [CFG_W-1:0]         poll_count_ff, poll_count_in;
   logic                     entry_mode_ff, entry_mode_in;
   logic [INDEX_W-1:0]       entry_index_ff, entry_index_in;
   logic [SYM_W-1:0]         symbols_ff [CODE_LENGTH];
   logic                     symbol_held_ff, symbol_held_in;
   logic [1:0]               lamp_mode_ff, lamp_mode_in;
   logic [BLINK_TOTAL_W-1:0] blink_total_ff, blink_total_in;
   logic [BLINK_PHASE_W-1:0] blink_phase_ff, blink_phase_in;
   logic                     request_ff, request_in;
   logic                     mismatch_ff, mismatch_in;
   logic [SEG_W-1:0]         segment_ff, segment_in;
   logic [LAMP_W-1:0]        lamp_ff, lamp_in;

   // result register
   logic              rsp_valid_ff;
   logic [COIL_W-1:0] rsp_coil_ff;
   logic [SEG_W-1:0]  rsp_segment_ff;
   logic [LAMP_W-1:0] rsp_lamps_ff;
   logic              rsp_open_ff;
   logic              rsp_busy_ff;

   logic               accept;
   logic               poll_hit;
   logic               store_en;
   logic [SYM_W-1:0]   store_sym;
   logic               code_match;
   logic               request_mid;
   motor_status_type   motor;

   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign accept       = req_ch.valid & req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign poll_hit     = (poll_count_ff >= poll_period_ff);

   always_comb begin
      code_match = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (2 * i < CODE_W) begin
            if (symbols_ff[i] != code_word_ff[2*i +: SYM_W]) code_match = 1'b0;
         end else if (symbols_ff[i] != SYM_UP) begin
            code_match = 1'b0;
         end
      end
   end

   always_comb begin
      poll_count_in  = poll_count_ff;
      entry_mode_in  = entry_mode_ff;
      entry_index_in = entry_index_ff;
      symbol_held_in = symbol_held_ff;
      lamp_mode_in   = lamp_mode_ff;
      blink_total_in = blink_total_ff;
      blink_phase_in = blink_phase_ff;
      request_mid    = request_ff;
      mismatch_in    = mismatch_ff;
      segment_in     = segment_ff;
      lamp_in        = lamp_ff;
      store_en       = 1'b0;
      store_sym      = SYM_UP;

      if (poll_hit) begin
         poll_count_in = CFG_W'(1);

         // entry poll: stick is ignored while a matched code is turning
         if (!(entry_mode_ff == ENTRY_UNLOCK && request_ff)) begin
            entry_mode_in = ENTRY_READING;
            priority if (req_ch.x_sample < left_limit_ff) begin
               segment_in = SEG_LEFT;
               store_sym  = SYM_LEFT;
               store_en   = 1'b1;
            end else if (req_ch.x_sample > right_limit_ff) begin
               segment_in = SEG_RIGHT;
               store_sym  = SYM_RIGHT;
               store_en   = 1'b1;
            end else if (req_ch.y_sample > up_limit_ff) begin
               segment_in = SEG_UP;
               store_sym  = SYM_UP;
               store_en   = 1'b1;
            end else if (req_ch.y_sample < down_limit_ff) begin
               segment_in = SEG_DOWN;
               store_sym  = SYM_DOWN;
               store_en   = 1'b1;
            end else begin
               segment_in = SEG_NEUTRAL;
            end
            if (store_en) begin
               symbol_held_in = 1'b1;
            end else if (symbol_held_ff) begin
               // release after a deflection
               symbol_held_in = 1'b0;
               if (entry_index_ff >= INDEX_LAST) begin
                  entry_index_in = '0;
                  if (code_match) begin
                     request_mid   = 1'b1;
                     entry_mode_in = ENTRY_UNLOCK;
                  end else begin
                     mismatch_in = 1'b1;
                  end
               end else begin
                  entry_index_in = entry_index_ff + INDEX_W'(1);
               end
            end
         end

         // lamp poll
         unique case (lamp_mode_ff)
            LAMP_IDLE: begin
               if (mismatch_in) lamp_mode_in = LAMP_BLINK;
               else if (request_mid) lamp_mode_in = LAMP_ON;
            end
            LAMP_ON: begin
               if (!request_mid) lamp_mode_in = LAMP_IDLE;
            end
            default: begin
               if (blink_total_ff >= BLINK_PERIODS) begin
                  blink_total_in = BLINK_TOTAL_W'(1);
                  blink_phase_in = BLINK_PHASE_W'(1);
                  mismatch_in    = 1'b0;
                  lamp_mode_in   = LAMP_IDLE;
               end else begin
                  blink_total_in = blink_total_ff + BLINK_TOTAL_W'(1);
                  blink_phase_in = blink_phase_ff + BLINK_PHASE_W'(1);
               end
            end
         endcase
         unique case (lamp_mode_in)
            LAMP_IDLE: lamp_in = LAMP_W'(entry_index_in);
            LAMP_ON:   lamp_in = LAMPS_ON;
            default: begin
               if (blink_phase_in < BLINK_ON_LIMIT) begin
                  lamp_in = LAMPS_ON;
               end else begin
                  lamp_in        = LAMPS_OFF;
                  blink_phase_in = '0;
               end
            end
         endcase
      end else if (poll_count_ff < POLL_MAX) begin
         poll_count_in = poll_count_ff + CFG_W'(1);
      end
   end

   assign request_in = request_mid & ~motor.finish;

   jcl_motor u_motor (
      .clock      (clock),
      .reset      (reset),
      .step_en    (accept),
      .request    (request_mid),
      .turn_steps (turn_steps_ff),
      .status     (motor)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_period_ff <= RST_POLL_PERIOD;
         left_limit_ff  <= RST_LEFT_LIMIT;
         right_limit_ff <= RST_RIGHT_LIMIT;
         up_limit_ff    <= RST_UP_LIMIT;
         down_limit_ff  <= RST_DOWN_LIMIT;
         turn_steps_ff  <= RST_TURN_STEPS;
         code_word_ff   <= RST_CODE_WORD;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_POLL_PERIOD: poll_period_ff <= csr_ch.data;
            REG_LEFT_LIMIT:  left_limit_ff  <= csr_ch.data;
            REG_RIGHT_LIMIT: right_limit_ff <= csr_ch.data;
            REG_UP_LIMIT:    up_limit_ff    <= csr_ch.data;
            REG_DOWN_LIMIT:  down_limit_ff  <= csr_ch.data;
            REG_TURN_STEPS:  turn_steps_ff  <= csr_ch.data;
            REG_CODE_WORD:   code_word_ff   <= csr_ch.data[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_count_ff  <= '0;
         entry_mode_ff  <= ENTRY_READING;
         entry_index_ff <= '0;
         symbol_held_ff <= 1'b0;
         lamp_mode_ff   <= LAMP_IDLE;
         blink_total_ff <= '0;
         blink_phase_ff <= '0;
         request_ff     <= 1'b0;
         mismatch_ff    <= 1'b0;
         segment_ff     <= '0;
         lamp_ff        <= '0;
      end else if (accept) begin
         poll_count_ff  <= poll_count_in;
         entry_mode_ff  <= entry_mode_in;
         entry_index_ff <= entry_index_in;
         symbol_held_ff <= symbol_held_in;
         lamp_mode_ff   <= lamp_mode_in;
         blink_total_ff <= blink_total_in;
         blink_phase_ff <= blink_phase_in;
         request_ff     <= request_in;
         mismatch_ff    <= mismatch_in;
         segment_ff     <= segment_in;
         lamp_ff        <= lamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && store_en) begin
         symbols_ff[entry_index_ff] <= store_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_coil_ff    <= motor.coil;
         rsp_segment_ff <= segment_in;
         rsp_lamps_ff   <= lamp_in;
         rsp_open_ff    <= motor.is_open;
         rsp_busy_ff    <= motor.busy;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.coil_phase   = rsp_coil_ff;
   assign rsp_ch.segment_code = rsp_segment_ff;
   assign rsp_ch.status_lamps = rsp_lamps_ff;
   assign rsp_ch.is_open      = rsp_open_ff;
   assign rsp_ch.motor_busy   = rsp_busy_ff;

endmodule

### tb/tb_joystick_code_lock_stepper_core.sv
// self-checking testbench for the joystick code lock stepper core
`timescale 1ns / 1ps

module tb_joystick_code_lock_stepper_core;
   import jcl_pkg::*;

   localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
   localparam int DRAIN_CYCLES    = 4;
   localparam int CYCLE_LIMIT     = 800_000;
   localparam int PRESSURE_AFTER  = 150;
   localparam int PRESSURE_CYCLES = 120;
   localparam int DIRECTED_ROWS   = 25;
   localparam int NUM_SETTINGS    = 8;

   // index past the code word, dropped by the block
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [COIL_W-1:0] coil_phase;
      logic [SEG_W-1:0]  segment_code;
      logic [LAMP_W-1:0] status_lamps;
      logic              is_open;
      logic              motor_busy;
   } lock_view_type;

   localparam lock_view_type ZERO_VIEW = '0;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CFG_W-1:0]     wdata;
      logic [SAMPLE_W-1:0]  x_sample;
      logic [SAMPLE_W-1:0]  y_sample;
      logic                 typed;
      lock_view_type        want;
   } stim_row_type;

   typedef struct packed {
      logic [CFG_W-1:0]  poll_period;
      logic [CFG_W-1:0]  left_limit;
      logic [CFG_W-1:0]  right_limit;
      logic [CFG_W-1:0]  up_limit;
      logic [CFG_W-1:0]  down_limit;
      logic [CFG_W-1:0]  turn_steps;
      logic [CODE_W-1:0] code_word;
      logic [15:0]       items;
   } setting_type;

   // values 0..3 line up with the code symbols
   typedef enum logic [2:0] {
      POS_UP, POS_RIGHT, POS_LEFT, POS_DOWN, POS_NEUTRAL, POS_NOISE
   } stick_pos_type;

   // neutral is x 500, y 10 under the reset limits
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd0,    10'd0,    1'b1, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd1023, 10'd1023, 1'b1, ZERO_VIEW},
      '{ROW_WRITE, REG_POLL_PERIOD, 10'd1,    10'd0,    10'd0,    1'b0, ZERO_VIEW},
      '{ROW_WRITE, REG_TURN_STEPS,  10'd3,    10'd0,    10'd0,    1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd1023, 1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd1023, 10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd0,    10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd0,    1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd0,    10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd0,    1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd1023, 10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd1023, 1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd0,    10'd10,   1'b0, ZERO_VIEW},
      '{ROW_TICK,  REG_POLL_PERIOD, 10'd0,    10'd500,  10'd10,   1'b0, ZERO_VIEW},
      '{ROW_WRITE, REG_UNUSED,      10'd1023, 10'd0,    10'd0,    1'b0, ZERO_VIEW}
   };

   setting_type settings [NUM_SETTINGS] = '{
      '{10'd1,    10'd300,  10'd700,  10'd700,  10'd300,  10'd5,    8'hB1, 16'd80},
      '{10'd3,    10'd100,  10'd900,  10'd900,  10'd100,  10'd1,    8'hFF, 16'd60},
      '{10'd0,    10'd512,  10'd512,  10'd512,  10'd512,  10'd0,    8'h00, 16'd40},
      '{10'd2,    10'd0,    10'd1023, 10'd1023, 10'd0,    10'd4,    8'h5A, 16'd20},
      '{10'd1,    10'd1023, 10'd0,    10'd0,    10'd1023, 10'd2,    8'h27, 16'd20},
      '{10'd1,    10'd400,  10'd600,  10'd20,   10'd1,    10'd40,   8'hE4, 16'd150},
      '{10'd1023, 10'd200,  10'd800,  10'd800,  10'd200,  10'd2,    8'h1B, 16'd30},
      '{10'd2,    10'd350,  10'd650,  10'd650,  10'd350,  10'd8,    8'hC6, 16'd60}
   };

   logic clock = 1'b0;
   logic reset;

   jcl_req_if req_if ();
   jcl_rsp_if rsp_if ();
   jcl_csr_if csr_if ();

   joystick_code_lock_stepper_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register copy
   logic [CFG_W-1:0]  cfg_poll, cfg_left, cfg_right, cfg_up, cfg_down, cfg_turn;
   logic [CODE_W-1:0] cfg_code;

   // lock state copy
   int                       tick_count;
   logic                     entry_state;
   logic [INDEX_W-1:0]       code_pos;
   logic [SYM_W-1:0]         code_syms [CODE_LENGTH];
   logic                     stick_held;
   logic [1:0]               lamp_state;
   logic [BLINK_TOTAL_W-1:0] blink_count;
   logic [BLINK_PHASE_W-1:0] blink_step;
   logic [1:0]               motor_state;
   int                       coil_idx;
   logic [CFG_W-1:0]         turn_count;
   logic                     lock_open;
   logic                     turn_request;
   logic                     bad_code;
   logic [COIL_W-1:0]        coil_reg;
   logic [SEG_W-1:0]         glyph_reg;
   logic [LAMP_W-1:0]        lamp_reg;

   lock_view_type pending_views [$];
   stick_pos_type stick_plan [$];

   int  error_count     = 0;
   int  results_checked = 0;
   int  ticks_sent      = 0;
   int  code_hits       = 0;
   int  code_misses     = 0;
   int  turns_done      = 0;
   int  cycle_count     = 0;
   int  src_calm        = 0;
   int  sink_calm       = 0;
   logic pressure_done  = 1'b0;

   function automatic void log_error(input string what);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", what);
   endfunction

   // mostly zero, sometimes a short gap, rarely a long one; calm stretches have none
   function automatic int idle_length(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   function automatic void lock_reset();
      cfg_poll     = RST_POLL_PERIOD;
      cfg_left     = RST_LEFT_LIMIT;
      cfg_right    = RST_RIGHT_LIMIT;
      cfg_up       = RST_UP_LIMIT;
      cfg_down     = RST_DOWN_LIMIT;
      cfg_turn     = RST_TURN_STEPS;
      cfg_code     = RST_CODE_WORD;
      tick_count   = 0;
      entry_state  = ENTRY_READING;
      code_pos     = '0;
      stick_held   = 1'b0;
      lamp_state   = LAMP_IDLE;
      blink_count  = '0;
      blink_step   = '0;
      motor_state  = MOTOR_STAND;
      coil_idx     = 0;
      turn_count   = '0;
      lock_open    = 1'b0;
      turn_request = 1'b0;
      bad_code     = 1'b0;
      coil_reg     = '0;
      glyph_reg    = '0;
      lamp_reg     = '0;
   endfunction

   function automatic void lock_write(input logic [CSR_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] wdata);
      case (idx)
         REG_POLL_PERIOD: cfg_poll = wdata;
         REG_LEFT_LIMIT:  cfg_left = wdata;
         REG_RIGHT_LIMIT: cfg_right = wdata;
         REG_UP_LIMIT:    cfg_up = wdata;
         REG_DOWN_LIMIT:  cfg_down = wdata;
         REG_TURN_STEPS:  cfg_turn = wdata;
         REG_CODE_WORD:   cfg_code = wdata[CODE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void read_stick(input logic [SAMPLE_W-1:0] x, y);
      logic [SYM_W-1:0] sym;
      logic             deflected;
      logic             match;
      int               i;
      sym = SYM_UP;
      deflected = 1'b1;
      match = 1'b1;
      // a matched code holds the stick off until its turn is over
      if (entry_state == ENTRY_UNLOCK) begin
         if (turn_request) return;
         entry_state = ENTRY_READING;
      end
      if (x < cfg_left) begin
         glyph_reg = SEG_LEFT;
         sym = SYM_LEFT;
      end else if (x > cfg_right) begin
         glyph_reg = SEG_RIGHT;
         sym = SYM_RIGHT;
      end else if (y > cfg_up) begin
         glyph_reg = SEG_UP;
         sym = SYM_UP;
      end else if (y < cfg_down) begin
         glyph_reg = SEG_DOWN;
         sym = SYM_DOWN;
      end else begin
         deflected = 1'b0;
      end
      if (deflected) begin
         stick_held = 1'b1;
         code_syms[code_pos] = sym;
         return;
      end
      glyph_reg = SEG_NEUTRAL;
      if (!stick_held) return;
      stick_held = 1'b0;
      if (code_pos >= INDEX_LAST) begin
         code_pos = '0;
         for (i = 0; i < CODE_LENGTH; i++)
            if (code_syms[i] != cfg_code[2*i +: 2]) match = 1'b0;
         if (match) begin
            turn_request = 1'b1;
            entry_state = ENTRY_UNLOCK;
            code_hits++;
         end else begin
            bad_code = 1'b1;
            code_misses++;
         end
      end else begin
         code_pos = code_pos + 1'b1;
      end
   endfunction

   function automatic void update_lamps();
      case (lamp_state)
         LAMP_IDLE: begin
            if (turn_request) lamp_state = LAMP_ON;
            if (bad_code) lamp_state = LAMP_BLINK;
         end
         LAMP_ON: begin
            if (!turn_request) lamp_state = LAMP_IDLE;
         end
         default: begin
            // the poll that leaves blinking still advances both counters
            if (blink_count >= BLINK_PERIODS) begin
               blink_count = '0;
               blink_step = '0;
               bad_code = 1'b0;
               lamp_state = LAMP_IDLE;
            end
            blink_step = blink_step + 1'b1;
            blink_count = blink_count + 1'b1;
         end
      endcase
      case (lamp_state)
         LAMP_IDLE: lamp_reg = LAMP_W'(code_pos);
         LAMP_ON:   lamp_reg = LAMPS_ON;
         default: begin
            if (blink_step < BLINK_ON_LIMIT) begin
               lamp_reg = LAMPS_ON;
            end else begin
               lamp_reg = LAMPS_OFF;
               blink_step = '0;
            end
         end
      endcase
   endfunction

   function automatic logic [COIL_W-1:0] coil_for(input int idx);
      return COIL_TABLE[(idx * 8 / PHASE_COUNT) % 8];
   endfunction

   function automatic void step_motor();
      if (motor_state == MOTOR_STAND) begin
         if (!turn_request) return;
         motor_state = lock_open ? MOTOR_BACK : MOTOR_FWD;
         turn_count = '0;
      end
      if (turn_count < cfg_turn) begin
         if (motor_state == MOTOR_FWD) begin
            coil_reg = coil_for(coil_idx);
            coil_idx = (coil_idx + 1 >= PHASE_COUNT) ? 0 : coil_idx + 1;
         end else begin
            coil_idx = (coil_idx == 0 || coil_idx >= PHASE_COUNT) ? PHASE_COUNT - 1
                                                                  : coil_idx - 1;
            coil_reg = coil_for(coil_idx);
         end
         turn_count = turn_count + 1'b1;
      end else begin
         // one extra tick without a coil write closes the turn
         coil_idx = (motor_state == MOTOR_FWD) ? PHASE_COUNT - 1 : 0;
         turn_count = '0;
         turn_request = 1'b0;
         lock_open = ~lock_open;
         motor_state = MOTOR_STAND;
         turns_done++;
      end
   endfunction

   function automatic lock_view_type predict_view(input logic [SAMPLE_W-1:0] x, y);
      lock_view_type v;
      if (tick_count >= int'(cfg_poll)) begin
         tick_count = 1;
         read_stick(x, y);
         update_lamps();
      end else if (tick_count < SAMPLE_MAX) begin
         tick_count++;
      end
      step_motor();
      v.coil_phase   = coil_reg;
      v.segment_code = glyph_reg;
      v.status_lamps = lamp_reg;
      v.is_open      = lock_open;
      v.motor_busy   = (motor_state != MOTOR_STAND);
      return v;
   endfunction

   // a reading the limits classify as pos, else random; a right pick may read left
   function automatic void pick_sample(input stick_pos_type pos,
                                       output logic [SAMPLE_W-1:0] x, y);
      logic mid_x, mid_y;
      mid_x = (cfg_left <= cfg_right);
      mid_y = (cfg_down <= cfg_up);
      x = SAMPLE_W'($urandom);
      y = SAMPLE_W'($urandom);
      case (pos)
         POS_LEFT: begin
            if (cfg_left != 0) x = SAMPLE_W'($urandom_range(0, int'(cfg_left) - 1));
         end
         POS_RIGHT: begin
            if (cfg_right != SAMPLE_MAX)
               x = SAMPLE_W'($urandom_range(int'(cfg_right) + 1, SAMPLE_MAX));
         end
         POS_UP: begin
            if (mid_x && cfg_up != SAMPLE_MAX) begin
               x = SAMPLE_W'($urandom_range(cfg_left, cfg_right));
               y = SAMPLE_W'($urandom_range(int'(cfg_up) + 1, SAMPLE_MAX));
            end
         end
         POS_DOWN: begin
            if (mid_x && cfg_down != 0) begin
               x = SAMPLE_W'($urandom_range(cfg_left, cfg_right));
               y = SAMPLE_W'($urandom_range(0, int'(cfg_down) - 1));
            end
         end
         POS_NEUTRAL: begin
            if (mid_x && mid_y) begin
               x = SAMPLE_W'($urandom_range(cfg_left, cfg_right));
               y = SAMPLE_W'($urandom_range(cfg_down, cfg_up));
            end
         end
         default: ;
      endcase
   endfunction

   // queue the stick positions of one code attempt, one entry per poll
   function automatic void plan_attempt();
      int               r, n, fill, i;
      logic [SYM_W-1:0] sym;
      r = $urandom_range(0, 99);
      if (r >= 85) begin
         repeat ($urandom_range(1, 4)) stick_plan.push_back(POS_NOISE);
         return;
      end
      // pad with junk symbols so the attempt starts at the first code position
      fill = (CODE_LENGTH - (int'(code_pos) + int'(stick_held)) % CODE_LENGTH)
             % CODE_LENGTH;
      n = (r >= 75) ? $urandom_range(1, CODE_LENGTH - 1) : CODE_LENGTH;
      for (i = 0; i < fill + n; i++) begin
         if (i >= fill && (r < 55 || r >= 75)) sym = cfg_code[2*(i-fill) +: 2];
         else sym = SYM_W'($urandom_range(0, 3));
         repeat ($urandom_range(1, 2)) stick_plan.push_back(stick_pos_type'(sym));
         repeat ($urandom_range(1, 2)) stick_plan.push_back(POS_NEUTRAL);
      end
   endfunction

   task automatic send_tick(input logic [SAMPLE_W-1:0] x, y, input logic typed,
                            input lock_view_type want);
      lock_view_type predicted;
      repeat (idle_length(src_calm)) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid    <= 1'b1;
      req_if.x_sample <= x;
      req_if.y_sample <= y;
      do @(posedge clock); while (!req_if.ready);
      predicted = predict_view(x, y);
      pending_views.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] wdata);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= wdata;
      do @(posedge clock); while (!csr_if.ready);
      lock_write(idx, wdata);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // stop offering ticks and wait until every result is back
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      stick_pos_type       pos;
      logic [SAMPLE_W-1:0] x, y;
      int                  i, p;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.x_sample = '0;
      req_if.y_sample = '0;
      csr_if.valid    = 1'b0;
      csr_if.index    = REG_POLL_PERIOD;
      csr_if.data     = '0;
      lock_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].wdata);
         end else begin
            send_tick(directed_rows[i].x_sample, directed_rows[i].y_sample,
                      directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (p = 0; p < NUM_SETTINGS; p++) begin
         settle();
         write_reg(REG_POLL_PERIOD, settings[p].poll_period);
         write_reg(REG_LEFT_LIMIT, settings[p].left_limit);
         write_reg(REG_RIGHT_LIMIT, settings[p].right_limit);
         write_reg(REG_UP_LIMIT, settings[p].up_limit);
         write_reg(REG_DOWN_LIMIT, settings[p].down_limit);
         write_reg(REG_TURN_STEPS, settings[p].turn_steps);
         // upper data bits must be ignored for the code word
         write_reg(REG_CODE_WORD, {2'($urandom_range(0, 3)), settings[p].code_word});
         stick_plan.delete();
         repeat (settings[p].items) begin
            pos = POS_NOISE;
            // only a tick that polls needs a planned stick position
            if (tick_count >= int'(cfg_poll) &&
                !(entry_state == ENTRY_UNLOCK && turn_request)) begin
               if (stick_plan.size() == 0) plan_attempt();
               pos = stick_plan.pop_front();
            end
            pick_sample(pos, x, y);
            send_tick(x, y, 1'b0, ZERO_VIEW);
         end
      end

      settle();
      if (pending_views.size() != 0)
         log_error($sformatf("%0d results never arrived", pending_views.size()));
      $display("%0d ticks over %0d register settings, %0d results compared, %0d errors",
               ticks_sent, NUM_SETTINGS + 2, results_checked, error_count);
      $display("%0d codes accepted, %0d rejected, %0d motor turns completed",
               code_hits, code_misses, turns_done);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result sink with random back-pressure and one long hold-off
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && results_checked >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold = PRESSURE_CYCLES;
         end
         if (hold == 0) hold = idle_length(sink_calm);
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lock_view_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.coil_phase   = rsp_if.coil_phase;
         got.segment_code = rsp_if.segment_code;
         got.status_lamps = rsp_if.status_lamps;
         got.is_open      = rsp_if.is_open;
         got.motor_busy   = rsp_if.motor_busy;
         results_checked++;
         if (pending_views.size() == 0) begin
            log_error($sformatf("result transaction with nothing expected: %p", got));
         end else begin
            want = pending_views.pop_front();
            if (got.coil_phase !== want.coil_phase ||
                got.segment_code !== want.segment_code ||
                got.status_lamps !== want.status_lamps ||
                got.is_open !== want.is_open ||
                got.motor_busy !== want.motor_busy)
               log_error($sformatf({"result %0d exp/act: coil %h/%h seg %h/%h ",
                                    "lamps %0d/%0d open %b/%b busy %b/%b"},
                                   results_checked, want.coil_phase, got.coil_phase,
                                   want.segment_code, got.segment_code,
                                   want.status_lamps, got.status_lamps,
                                   want.is_open, got.is_open,
                                   want.motor_busy, got.motor_busy));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_views.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

### files.f
rtl/core/jcl_pkg.sv
rtl/core/jcl_if.sv
rtl/core/jcl_motor.sv
rtl/core/joystick_code_lock_stepper_core.sv
tb/tb_joystick_code_lock_stepper_core.sv
